[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SEMFW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define SEMFW_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[hdl/semfw_pkg.sv]
package semfw_pkg;

  localparam int PID_W  = 5;
  localparam int IDX_W  = 5;
  localparam int INIT_W = 8;
  localparam int CNT_W  = 10;

  typedef logic signed [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX = cnt_t'(511);
  localparam cnt_t CNT_MIN = cnt_t'(-512);

  // request modes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_SIGNAL = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_BLOCKED = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  sem_index;
    logic [INIT_W-1:0] init_value;
    logic [PID_W-1:0]  caller_pid;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_out;
    logic             woken_valid;
    logic [PID_W-1:0] woken_pid;
  } rsp_t;

  // one semaphore table entry
  typedef struct packed {
    cnt_t             count;
    logic [PID_W-1:0] head;
    logic [PID_W-1:0] tail;
  } sem_word_t;

endpackage

[hdl/semfw_ram.sv]
module semfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/semaphore_unit_fifo_wait.sv]
// Counting semaphore table with a FIFO wait queue per semaphore. A request is
// taken at a rising edge with start high and busy low; its result appears on
// out_rsp for exactly one cycle with out_valid high. Create, wait and unused
// modes, and signals that leave the queue empty, are answered from state S_SEM
// once the registered read of the semaphore table RAM returns; a signal that
// pops a waiter while others stay queued goes on to S_LINK for a dependent
// read of the waiter link RAM. busy drops in the strobe cycle, so the next
// request may be taken there. The receiver cannot stall: a result not
// captured in its strobe cycle is gone. Slot claim, queue occupancy and
// count-written flags sit in flops cleared by reset, so the block is usable
// right after reset with no clearing pass. Create takes the lowest unclaimed
// slot.
module semaphore_unit_fifo_wait #(
  parameter int NUM_SEMS  = 32,
  parameter int NUM_PROCS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  semfw_pkg::req_t  in_req,
  output logic             out_valid,
  output semfw_pkg::rsp_t  out_rsp
);

  localparam int SEM_AW  = $clog2(NUM_SEMS);
  localparam int PROC_AW = $clog2(NUM_PROCS);
  localparam int WORD_W  = $bits(semfw_pkg::sem_word_t);

  // one-hot sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a request
    S_SEM  = 3'b010,  // table entry read data valid, modify and write back
    S_LINK = 3'b100   // link read data valid, advance the queue head
  } state_t;

  state_t state_r, state_nxt;

  // per-slot flags, cleared by reset
  logic [NUM_SEMS-1:0] claimed_r, claimed_nxt;
  logic [NUM_SEMS-1:0] nonempty_r, nonempty_nxt;
  logic [NUM_SEMS-1:0] cvld_r, cvld_nxt;  // count written since reset

  // request held while it is worked on
  semfw_pkg::req_t        req_r;
  logic [SEM_AW-1:0]      addr_r;
  logic                   found_r;
  logic                   sem_ok_r;  // slot in range
  logic                   pid_ok_r;  // caller in range
  semfw_pkg::sem_word_t   pend_r, pend_nxt;

  semfw_pkg::rsp_t        rsp_r, rsp_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // priority search for the lowest free slot
  logic [SEM_AW-1:0] free_idx;
  logic              free_found;

  always_comb begin
    free_idx   = '0;
    free_found = ~&claimed_r;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!claimed_r[i]) begin
        free_idx = SEM_AW'(i);
      end
    end
  end

  wire accept = start && (state_r == S_IDLE);

  // semaphore table RAM
  logic                 sem_we;
  logic [SEM_AW-1:0]    sem_raddr;
  semfw_pkg::sem_word_t sem_wd, sem_rd;
  logic [WORD_W-1:0]    sem_rd_raw;

  // waiter link RAM, one entry per process
  logic                 lnk_we;
  logic [PROC_AW-1:0]   lnk_waddr, lnk_raddr;
  logic [semfw_pkg::PID_W-1:0] lnk_wd, lnk_rd;

  assign sem_raddr = (in_req.mode == semfw_pkg::MODE_CREATE) ?
                     free_idx : SEM_AW'(in_req.sem_index);

  semfw_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SEMS)) u_sem_ram (
    .clk   (clk),
    .we    (sem_we),
    .waddr (addr_r),
    .wdata (sem_wd),
    .raddr (sem_raddr),
    .rdata (sem_rd_raw)
  );

  assign sem_rd = semfw_pkg::sem_word_t'(sem_rd_raw);

  semfw_ram #(.WIDTH(semfw_pkg::PID_W), .DEPTH(NUM_PROCS)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wd),
    .raddr (lnk_raddr),
    .rdata (lnk_rd)
  );

  // the head being popped is looked up while the entry is modified
  assign lnk_raddr = PROC_AW'(sem_rd.head);

  // current entry with an unwritten count reading as zero
  semfw_pkg::cnt_t cur_cnt, dec_cnt, inc_cnt;
  logic            cur_ne;

  always_comb begin
    cur_cnt = cvld_r[addr_r] ? sem_rd.count : '0;
    cur_ne  = nonempty_r[addr_r];
    // wait saturates low, signal saturates high
    dec_cnt = (cur_cnt != semfw_pkg::CNT_MIN) ? cur_cnt - 1'b1 : cur_cnt;
    inc_cnt = (cur_cnt != semfw_pkg::CNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
  end

  always_comb begin
    state_nxt     = state_r;
    claimed_nxt   = claimed_r;
    nonempty_nxt  = nonempty_r;
    cvld_nxt      = cvld_r;
    pend_nxt      = pend_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = 1'b0;
    sem_we        = 1'b0;
    sem_wd        = sem_rd;
    lnk_we        = 1'b0;
    lnk_waddr     = PROC_AW'(sem_rd.tail);
    lnk_wd        = req_r.caller_pid;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SEM;
        end
      end

      S_SEM: begin
        rsp_nxt       = '0;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (req_r.mode)
          semfw_pkg::MODE_CREATE: begin
            if (found_r) begin
              sem_we               = 1'b1;
              sem_wd.count         = semfw_pkg::cnt_t'({2'b00, req_r.init_value});
              claimed_nxt[addr_r]  = 1'b1;
              nonempty_nxt[addr_r] = 1'b0;
              cvld_nxt[addr_r]     = 1'b1;
              rsp_nxt.slot_out     = semfw_pkg::IDX_W'(addr_r);
            end else begin
              rsp_nxt.status = semfw_pkg::STAT_NOFREE;
            end
          end

          semfw_pkg::MODE_WAIT: begin
            if (sem_ok_r && pid_ok_r) begin
              sem_we           = 1'b1;
              cvld_nxt[addr_r] = 1'b1;
              sem_wd.count     = dec_cnt;
              if (dec_cnt < 0) begin
                rsp_nxt.status = semfw_pkg::STAT_BLOCKED;
                if (cur_ne) begin
                  // link old tail to the caller
                  lnk_we      = (32'(sem_rd.tail) < NUM_PROCS);
                  sem_wd.tail = req_r.caller_pid;
                end else begin
                  sem_wd.head          = req_r.caller_pid;
                  sem_wd.tail          = req_r.caller_pid;
                  nonempty_nxt[addr_r] = 1'b1;
                end
              end
            end
          end

          semfw_pkg::MODE_SIGNAL: begin
            if (sem_ok_r) begin
              cvld_nxt[addr_r] = 1'b1;
              sem_wd.count     = inc_cnt;
              if (cur_ne) begin
                rsp_nxt.woken_valid = 1'b1;
                rsp_nxt.woken_pid   = sem_rd.head;
                if (sem_rd.head == sem_rd.tail) begin
                  sem_we               = 1'b1;
                  nonempty_nxt[addr_r] = 1'b0;
                end else begin
                  // head advances once the link read returns
                  pend_nxt      = sem_wd;
                  state_nxt     = S_LINK;
                  out_valid_nxt = 1'b0;
                end
              end else begin
                sem_we = 1'b1;
              end
            end
          end

          default: begin
          end
        endcase
      end

      S_LINK: begin
        sem_we        = 1'b1;
        sem_wd        = pend_r;
        sem_wd.head   = (32'(pend_r.head) < NUM_PROCS) ? lnk_rd : '0;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      claimed_r   <= '0;
      nonempty_r  <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      claimed_r   <= claimed_nxt;
      nonempty_r  <= nonempty_nxt;
      cvld_r      <= cvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req;
      addr_r   <= sem_raddr;
      found_r  <= free_found;
      sem_ok_r <= (32'(in_req.sem_index) < NUM_SEMS);
      pid_ok_r <= (32'(in_req.caller_pid) < NUM_PROCS);
    end
    pend_r <= pend_nxt;
    rsp_r  <= rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

[hdl/semfw_checker.sv]
`include "assert_macros.svh"

module semfw_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input semfw_pkg::req_t in_req,
  input logic            out_valid,
  input semfw_pkg::rsp_t out_rsp
);

  wire accept = start && !busy;

  // an accepted request keeps the block busy in the next cycle
  `SEMFW_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> busy, "not busy after accept")

  // a result strobe lasts one cycle and comes with busy low
  `SEMFW_ASSERT(a_strobe_pulse, clk, rst_n, out_valid |-> !busy ##1 !out_valid,
    "result strobe not a single idle-cycle pulse")

  // a blocked caller never also wakes anyone or names a slot
  `SEMFW_NEVER(a_blocked_clean, clk, rst_n,
    out_valid && (out_rsp.status == semfw_pkg::STAT_BLOCKED) &&
    (out_rsp.woken_valid || (out_rsp.slot_out != '0)), "blocked result carries extra data")

  // a wake comes only from a successful signal
  `SEMFW_ASSERT(a_wake_ok, clk, rst_n,
    out_valid && out_rsp.woken_valid |-> out_rsp.status == semfw_pkg::STAT_OK,
    "wake with non-ok status")

  // the unused mode answers with an all-zero result
  `SEMFW_ASSERT(a_unused_mode, clk, rst_n,
    accept && (in_req.mode == semfw_pkg::MODE_UNUSED) |-> ##2 out_valid && (out_rsp == '0),
    "unused mode result wrong")

endmodule

bind semaphore_unit_fifo_wait semfw_checker u_semfw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
